>>> rtl/rgoc_pkg.sv
// Shared types and constants for the one-cell raster grow block.
// Holds the item structs, configuration register indexes and sizing constants.
// No dependencies.
package rgoc_pkg;

  // Sizing
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int DIM_BITS   = 13;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int CNT_BITS   = 24;
  localparam int TOTAL_BITS = CNT_BITS + 1;
  localparam int VAL_BITS   = 32;
  localparam int CELL_BITS  = VAL_BITS + 1;
  localparam int LINE_BITS  = 2 * CELL_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;

  // Item modes
  localparam logic MODE_CELL  = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GROW_DIAG    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_OLD_EN       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_OLD_VALUE    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_NEW_EN       = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_NEW_VALUE    = 3'd6;

  // Reset values of the size registers
  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic                       mode;
    logic signed [VAL_BITS-1:0] cell_value;
    logic                       cell_null;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_BITS-1:0] out_value;
    logic                       out_null;
    logic                       row_end;
    logic                       frame_end;
  } out_item_t;

  typedef struct packed {
    logic [DIM_BITS-1:0]        image_width;
    logic [DIM_BITS-1:0]        image_height;
    logic                       grow_diagonal;
    logic                       old_override_enable;
    logic signed [VAL_BITS-1:0] old_value;
    logic                       new_override_enable;
    logic signed [VAL_BITS-1:0] new_value;
  } cfg_t;

  // One stored raster cell
  typedef struct packed {
    logic                is_null;
    logic [VAL_BITS-1:0] val;
  } cell_t;

  // Per-item control from the counter stage to the window stage
  typedef struct packed {
    logic                emit;
    logic [COL_BITS-1:0] col;
    logic                up;
    logic                dn;
    logic                lf;
    logic                rt;
    logic                row_end;
    logic                frame_end;
    cell_t               pix;
  } ctrl_t;

  // Window stage status back to the top level
  typedef struct packed {
    logic busy;
    logic advance;
  } win_status_t;

  localparam cell_t NULL_CELL = '{is_null: 1'b1, val: '0};

endpackage

>>> rtl/rgoc_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
module rgoc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read into the data register; hold data when not reading
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/rgoc_ctrl.sv
// Input counters of the raster grow block: row/column position, edge flags,
// emission decision and end-of-frame handling. Depends on rgoc_pkg.
module rgoc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  rgoc_pkg::in_item_t item,
  input  rgoc_pkg::cfg_t  cfg,
  output logic            s0_valid,
  output rgoc_pkg::ctrl_t s0
);
  import rgoc_pkg::*;

  logic [DIM_BITS-1:0]   w_eff;
  logic [DIM_BITS-1:0]   h_eff;
  logic [TOTAL_BITS-1:0] total;

  logic [DIM_BITS-1:0]   row;
  logic [COL_BITS-1:0]   col;
  logic [CNT_BITS-1:0]   emitted;
  logic [DIM_BITS-1:0]   er;
  logic [COL_BITS-1:0]   ec;

  logic [DIM_BITS-1:0]   row_p;
  logic [COL_BITS-1:0]   col_p;
  logic [DIM_BITS-1:0]   col_inc;
  logic [DIM_BITS-1:0]   row_next;
  logic [COL_BITS-1:0]   col_next;
  logic [DIM_BITS-1:0]   ec_inc;
  logic [DIM_BITS:0]     er_inc;
  logic [TOTAL_BITS-1:0] emitted_inc;
  logic                  is_cell;

  // Clamp the size registers to their usable range
  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = DIM_BITS'(1);
    end else if (cfg.image_width > DIM_BITS'(MAX_WIDTH)) begin
      w_eff = DIM_BITS'(MAX_WIDTH);
    end else begin
      w_eff = cfg.image_width;
    end
    if (cfg.image_height == '0) begin
      h_eff = DIM_BITS'(1);
    end else if (cfg.image_height > DIM_BITS'(MAX_HEIGHT)) begin
      h_eff = DIM_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = cfg.image_height;
    end
  end

  // Register cells/frame; user must change sizes only if idle, unenforced
  always_ff @(posedge clk) begin
    total <= TOTAL_BITS'({{DIM_BITS{1'b0}}, w_eff} * h_eff);
  end

  // Decide whether the item takes part, and where it lands
  always_comb begin
    is_cell  = (item.mode == MODE_CELL);
    s0_valid = take && (is_cell ? (row < h_eff) : (row >= h_eff));

    if ({1'b0, col} >= w_eff) begin
      col_p = '0;
      row_p = row + DIM_BITS'(1);
    end else begin
      col_p = col;
      row_p = row;
    end

    col_inc = {1'b0, col_p} + DIM_BITS'(1);
    if (col_inc >= w_eff) begin
      col_next = '0;
      row_next = row_p + DIM_BITS'(1);
    end else begin
      col_next = col_inc[COL_BITS-1:0];
      row_next = row_p;
    end

    ec_inc      = {1'b0, ec} + DIM_BITS'(1);
    er_inc      = {1'b0, er} + (DIM_BITS+1)'(1);
    emitted_inc = {1'b0, emitted} + TOTAL_BITS'(1);

    s0.emit      = (row_p >= DIM_BITS'(2)) || ((row_p == DIM_BITS'(1)) && (col_p != '0));
    s0.col       = col_p;
    s0.up        = (er != '0);
    s0.dn        = (er_inc < {1'b0, h_eff});
    s0.lf        = (ec != '0);
    s0.rt        = (ec_inc < w_eff);
    s0.row_end   = (ec_inc == w_eff);
    s0.frame_end = (emitted_inc >= total);
    if (is_cell && !item.cell_null) begin
      s0.pix = '{is_null: 1'b0, val: item.cell_value};
    end else begin
      s0.pix = NULL_CELL;
    end
  end

  // Advance the counters; return to the frame start after the last result
  always_ff @(posedge clk) begin
    if (rst) begin
      row     <= '0;
      col     <= '0;
      emitted <= '0;
      er      <= '0;
      ec      <= '0;
    end else if (s0_valid) begin
      if (s0.emit && s0.frame_end) begin
        row     <= '0;
        col     <= '0;
        emitted <= '0;
        er      <= '0;
        ec      <= '0;
      end else begin
        row <= row_next;
        col <= col_next;
        if (s0.emit) begin
          emitted <= emitted_inc[CNT_BITS-1:0];
          if (ec_inc >= w_eff) begin
            ec <= '0;
            er <= er_inc[DIM_BITS-1:0];
          end else begin
            ec <= ec_inc[COL_BITS-1:0];
          end
        end
      end
    end
  end

endmodule

>>> rtl/rgoc_window.sv
// Window stage of the raster grow block: line memory read-modify-write, the
// 3x3 neighbourhood, neighbour selection and the output register.
// Depends on rgoc_pkg and rgoc_ram.
module rgoc_window (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s0_valid,
  input  rgoc_pkg::ctrl_t      s0,
  input  rgoc_pkg::cfg_t       cfg,
  input  logic                 res_stall,
  output logic                 res_valid,
  output rgoc_pkg::out_item_t  res_item,
  output rgoc_pkg::win_status_t status
);
  import rgoc_pkg::*;

  logic                 s1_valid;
  ctrl_t                s1;
  logic                 s1_adv;

  logic                 fwd_hit;
  logic [LINE_BITS-1:0] fwd_data;
  logic [LINE_BITS-1:0] rd_data;
  logic [LINE_BITS-1:0] line;
  logic [LINE_BITS-1:0] wr_data;
  cell_t                upper;
  cell_t                middle;

  // Window columns: w1 is the older, w2 the newer; index 0 top, 2 bottom
  cell_t                w1 [3];
  cell_t                w2 [3];

  cell_t                centre;
  cell_t                nb [8];
  logic [7:0]           ok;
  logic                 found;
  out_item_t            res_next;

  // Line memory: upper row in the top half, middle row in the bottom half
  rgoc_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1.col),
    .wr_data (wr_data),
    .rd_en   (s0_valid),
    .rd_addr (s0.col),
    .rd_data (rd_data)
  );

  // Stage advances when the output register is free or being emptied
  assign s1_adv         = s1_valid && (!res_valid || !res_stall);
  assign status.busy    = s1_valid;
  assign status.advance = s1_adv;

  // Take the write in flight when it hits the entry just read
  assign line    = fwd_hit ? fwd_data : rd_data;
  assign upper   = line[LINE_BITS-1:CELL_BITS];
  assign middle  = line[CELL_BITS-1:0];
  assign wr_data = {middle, s1.pix};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (s0_valid) begin
        s1_valid <= 1'b1;
        fwd_hit  <= s1_adv && (s1.col == s0.col);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Hold stage payload and last written line entry
  always_ff @(posedge clk) begin
    if (s0_valid) begin
      s1 <= s0;
    end
    if (s1_adv) begin
      fwd_data <= wr_data;
    end
  end

  // Pick the result from the shifted window
  always_comb begin
    centre = w2[1];
    nb[0] = w2[0];
    nb[1] = w1[1];
    nb[2] = middle;
    nb[3] = w2[2];
    nb[4] = w1[0];
    nb[5] = upper;
    nb[6] = w1[2];
    nb[7] = s1.pix;
    ok[0] = s1.up;
    ok[1] = s1.lf;
    ok[2] = s1.rt;
    ok[3] = s1.dn;
    ok[4] = cfg.grow_diagonal && s1.up && s1.lf;
    ok[5] = cfg.grow_diagonal && s1.up && s1.rt;
    ok[6] = cfg.grow_diagonal && s1.dn && s1.lf;
    ok[7] = cfg.grow_diagonal && s1.dn && s1.rt;

    found              = 1'b0;
    res_next.out_value = '0;
    res_next.out_null  = 1'b1;
    res_next.row_end   = s1.row_end;
    res_next.frame_end = s1.frame_end;
    if (!centre.is_null) begin
      res_next.out_null  = 1'b0;
      res_next.out_value = cfg.old_override_enable ? cfg.old_value : centre.val;
    end else begin
      for (int k = 0; k < 8; k++) begin
        if (!found && ok[k] && !nb[k].is_null) begin
          found              = 1'b1;
          res_next.out_null  = 1'b0;
          res_next.out_value = cfg.new_override_enable ? cfg.new_value : nb[k].val;
        end
      end
    end
  end

  // Shift the window; clear it after the last result of a frame
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        w1[r] <= NULL_CELL;
        w2[r] <= NULL_CELL;
      end
    end else if (s1_adv) begin
      if (s1.emit && s1.frame_end) begin
        for (int r = 0; r < 3; r++) begin
          w1[r] <= NULL_CELL;
          w2[r] <= NULL_CELL;
        end
      end else begin
        for (int r = 0; r < 3; r++) begin
          w1[r] <= w2[r];
        end
        w2[0] <= upper;
        w2[1] <= middle;
        w2[2] <= s1.pix;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv && s1.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.emit) begin
      res_item <= res_next;
    end
  end

endmodule

>>> rtl/raster_grow_one_cell.sv
// Top level of the one-cell raster grow block: configuration registers,
// input handshake and the counter and window stages. Depends on rgoc_pkg,
// rgoc_ctrl and rgoc_window.
//
// Usage: raster cells enter on the cell channel in row-major order, one item
// per clock when neither side stalls. Each cell is grown into its null
// neighbourhood and results leave on the res channel, one per centre cell,
// with row_end and frame_end marks. A result for a centre cell is produced
// once the cell one row and one column further on has arrived, i.e. after
// image_width+1 further items; it then passes through the window stage and
// the output register. After the last image cell, image_width+1 flush
// items drain the final row; flush items at other times and cells beyond the
// last row are taken and dropped. With res_stall low, throughput is one item
// per cycle, set by the single read and single write per cycle of the RAM.
// While the receiver stalls, the result is held in the output register and
// one further item may sit in the window stage; beyond that cell_stall rises.
// Reset clears the counters, the window and both stages and restores the
// registers to 640x480 with all options off. The line memory is not cleared.
// Configuration writes are taken at any edge but must only be made when idle.
module raster_grow_one_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cell_valid,
  output logic                                cell_stall,
  input  rgoc_pkg::in_item_t                  cell_item,
  output logic                                res_valid,
  input  logic                                res_stall,
  output rgoc_pkg::out_item_t                 res_item,
  input  logic                                cfg_write,
  input  logic [rgoc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rgoc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import rgoc_pkg::*;

  cfg_t        cfg;
  logic        take;
  logic        s0_valid;
  ctrl_t       s0;
  win_status_t status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width         <= WIDTH_RESET;
      cfg.image_height        <= HEIGHT_RESET;
      cfg.grow_diagonal       <= 1'b0;
      cfg.old_override_enable <= 1'b0;
      cfg.old_value           <= '0;
      cfg.new_override_enable <= 1'b0;
      cfg.new_value           <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width         <= cfg_data[DIM_BITS-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height        <= cfg_data[DIM_BITS-1:0];
        REG_GROW_DIAG:    cfg.grow_diagonal       <= cfg_data[0];
        REG_OLD_EN:       cfg.old_override_enable <= cfg_data[0];
        REG_OLD_VALUE:    cfg.old_value           <= cfg_data[VAL_BITS-1:0];
        REG_NEW_EN:       cfg.new_override_enable <= cfg_data[0];
        REG_NEW_VALUE:    cfg.new_value           <= cfg_data[VAL_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold input while the window stage is full and cannot move on
  assign cell_stall = status.busy && !status.advance;
  assign take       = cell_valid && !cell_stall;

  rgoc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (cell_item),
    .cfg      (cfg),
    .s0_valid (s0_valid),
    .s0       (s0)
  );

  rgoc_window u_window (
    .clk       (clk),
    .rst       (rst),
    .s0_valid  (s0_valid),
    .s0        (s0),
    .cfg       (cfg),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_item  (res_item),
    .status    (status)
  );

`ifndef ASSERT_OFF
  a_stage_fill: assert property (@(posedge clk) disable iff (rst)
    s0_valid |=> status.busy)
    else $error("window stage empty after taking an item");

  a_res_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(status.advance))
    else $error("result appeared without the window stage advancing");

  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.out_null |-> res_item.out_value == '0)
    else $error("null result carries a non-zero value");
`endif

endmodule

>>> sim/tb.sv
// Self-checking bench for raster_grow_one_cell: random frames with gaps, stalls and noise items.
// Predicts every grown cell in step with the input handshake and checks each result field.
// Depends on rgoc_pkg and raster_grow_one_cell.
module tb;
  import rgoc_pkg::*;

  localparam int REG_COUNT   = 7;
  localparam int DRAIN_WAIT  = 20;
  localparam int SMALL_ITEMS = 1000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_style_e;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cell_valid = 1'b0;
  logic                     cell_stall;
  in_item_t                 cell_item = '0;
  logic                     res_valid;
  logic                     res_stall = 1'b0;
  out_item_t                res_item;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Items waiting to be sent and grown cells waiting to come out
  in_item_t  raster_items [$];
  out_item_t grown_cells [$];
  int        fail_count = 0;

  // Mirror of the block: registers, line stores, window and counters
  cfg_t        grow_cfg;
  cell_t       upper_line [MAX_WIDTH];
  cell_t       middle_line [MAX_WIDTH];
  cell_t       win [3][3] = '{default: NULL_CELL};
  int unsigned row_count = 0;
  int unsigned col_count = 0;
  int unsigned emit_count = 0;

  raster_grow_one_cell DUT (
    .clk        (clk),
    .rst        (rst),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .cell_item  (cell_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Size register as the block sees it: zero acts as one, clamp at the maximum
  function automatic int unsigned clamp_dim(input int unsigned d, input int unsigned max_d);
    if (d == 0) return 1;
    if (d > max_d) return max_d;
    return d;
  endfunction

  // Advance the mirror by one accepted item; return 1 when a grown cell comes out
  function automatic bit grow_cell(input in_item_t it, output out_item_t res);
    int unsigned     w, h, col, er, ec;
    longint unsigned pos;
    cell_t           incoming;
    cell_t           ring [8];
    bit [7:0]        reach;
    bit              up, dn, lf, rt, dg;
    w = clamp_dim(32'(grow_cfg.image_width), MAX_WIDTH);
    h = clamp_dim(32'(grow_cfg.image_height), MAX_HEIGHT);
    res = '0;
    if (it.mode == MODE_CELL) begin
      // drop cells beyond the last row
      if (row_count >= h) return 1'b0;
      incoming = it.cell_null ? NULL_CELL : cell_t'{is_null: 1'b0, val: it.cell_value};
    end else begin
      // drop flushes before the last cell
      if (row_count < h) return 1'b0;
      incoming = NULL_CELL;
    end
    if (col_count >= w) begin
      col_count = 0;
      row_count = (row_count + 1) & 32'h1FFF;
    end
    col = col_count;
    pos = longint'(row_count) * w + col;

    // Shift the window and rotate the line stores
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = upper_line[col];
    win[1][2] = middle_line[col];
    win[2][2] = incoming;
    upper_line[col] = middle_line[col];
    middle_line[col] = incoming;

    col_count = col + 1;
    if (col_count >= w) begin
      col_count = 0;
      row_count = (row_count + 1) & 32'h1FFF;
    end
    if (pos < longint'(w) + 1) return 1'b0;

    // Neighbours in priority order: up, left, right, down, then the diagonals
    er = emit_count / w;
    ec = emit_count % w;
    up = er >= 1;
    dn = er + 1 < h;
    lf = ec >= 1;
    rt = ec + 1 < w;
    dg = grow_cfg.grow_diagonal;
    ring = '{win[0][1], win[1][0], win[1][2], win[2][1],
             win[0][0], win[0][2], win[2][0], win[2][2]};
    reach = {dg & dn & rt, dg & dn & lf, dg & up & rt, dg & up & lf, dn, rt, lf, up};

    res.out_null = 1'b1;
    if (!win[1][1].is_null) begin
      res.out_null  = 1'b0;
      res.out_value = grow_cfg.old_override_enable ? grow_cfg.old_value : win[1][1].val;
    end else begin
      for (int k = 0; k < 8; k++) begin
        if (res.out_null && reach[k] && !ring[k].is_null) begin
          res.out_null  = 1'b0;
          res.out_value = grow_cfg.new_override_enable ? grow_cfg.new_value : ring[k].val;
        end
      end
    end
    res.row_end   = (ec + 1 == w);
    res.frame_end = (emit_count + 1 >= w * h);

    // Restart the frame after its last cell
    if (res.frame_end) begin
      emit_count = 0;
      row_count  = 0;
      col_count  = 0;
      win = '{default: NULL_CELL};
    end else begin
      emit_count = (emit_count + 1) & 32'hFF_FFFF;
    end
    return 1'b1;
  endfunction

  function automatic in_item_t cell_of(input logic [VAL_BITS-1:0] v, input logic n);
    in_item_t it;
    it.mode       = MODE_CELL;
    it.cell_value = v;
    it.cell_null  = n;
    return it;
  endfunction

  function automatic in_item_t flush_item();
    in_item_t it;
    it.mode       = MODE_FLUSH;
    it.cell_value = $urandom;
    it.cell_null  = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t random_cell(input int unsigned null_pct);
    logic [VAL_BITS-1:0] v;
    case ($urandom_range(0, 15))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      2:       v = 32'hFFFF_FFFF;
      3:       v = 32'h0000_0000;
      default: v = $urandom;
    endcase
    return cell_of(v, $urandom_range(0, 99) < null_pct);
  endfunction

  // Queue one whole frame with stray items the block must drop; return the items that count
  function automatic int unsigned queue_frame(input int unsigned w, h, null_pct);
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 24) == 0) raster_items.push_back(flush_item());
      raster_items.push_back(random_cell(null_pct));
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) raster_items.push_back(random_cell(null_pct));
    end
    for (int unsigned i = 0; i <= w; i++) begin
      raster_items.push_back(flush_item());
      if (i < w && $urandom_range(0, 19) == 0) raster_items.push_back(random_cell(null_pct));
    end
    if ($urandom_range(0, 4) == 0) raster_items.push_back(flush_item());
    return w * h + w + 1;
  endfunction

  // Write every register, keeping the mirror in step; call only while idle
  task automatic configure(input int unsigned w, h, input bit dg, old_en,
                           input logic [VAL_BITS-1:0] old_v, input bit new_en,
                           input logic [VAL_BITS-1:0] new_v);
    logic [CFG_DATA_BITS-1:0] regs [REG_COUNT];
    regs[REG_IMAGE_WIDTH]  = w;
    regs[REG_IMAGE_HEIGHT] = h;
    regs[REG_GROW_DIAG]    = CFG_DATA_BITS'(dg);
    regs[REG_OLD_EN]       = CFG_DATA_BITS'(old_en);
    regs[REG_OLD_VALUE]    = old_v;
    regs[REG_NEW_EN]       = CFG_DATA_BITS'(new_en);
    regs[REG_NEW_VALUE]    = new_v;
    grow_cfg.image_width         = DIM_BITS'(w);
    grow_cfg.image_height        = DIM_BITS'(h);
    grow_cfg.grow_diagonal       = dg;
    grow_cfg.old_override_enable = old_en;
    grow_cfg.old_value           = old_v;
    grow_cfg.new_override_enable = new_en;
    grow_cfg.new_value           = new_v;
    for (int i = 0; i < REG_COUNT; i++) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_BITS'(i);
      cfg_data  <= regs[i];
    end
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait for all items to go in and all grown cells to come out, then let the pipe drain
  task automatic settle();
    while (raster_items.size() != 0 || cell_valid || grown_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Sender: bursts of random length with random gaps; hold the payload while stalled
  int burst_left = 0;
  int gap_left   = 0;
  always @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (!cell_valid || !cell_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        cell_valid <= 1'b0;
      end else if (raster_items.size() > 0) begin
        cell_item  <= raster_items.pop_front();
        cell_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        cell_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall in changing styles, with long hold-offs while the sender is busy
  stall_style_e stall_style = STALL_NONE;
  int           style_left  = 0;
  int           hold_left   = 0;
  int           taken_count = 0;
  int           next_hold   = 200;
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) taken_count++;
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else if (taken_count >= next_hold && raster_items.size() > 64) begin
        hold_left = $urandom_range(150, 300);
        next_hold = taken_count + 1500;
        res_stall <= 1'b1;
      end else begin
        if (style_left == 0) begin
          stall_style = stall_style_e'($urandom_range(0, 3));
          style_left  = $urandom_range(32, 256);
        end else begin
          style_left--;
        end
        case (stall_style)
          STALL_NONE:  res_stall <= 1'b0;
          STALL_LIGHT: res_stall <= ($urandom_range(0, 7) == 0);
          STALL_HEAVY: res_stall <= 1'($urandom_range(0, 1));
          default:     res_stall <= ~res_stall;
        endcase
      end
    end
  end

  // Predict on each accepted item, then check each accepted result against the oldest
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst) begin
      if (cell_valid && !cell_stall) begin
        if (grow_cell(cell_item, want)) grown_cells.push_back(want);
      end
      if (res_valid && !res_stall) begin
        if (grown_cells.size() == 0) begin
          $error("unexpected result: out_value %0d, out_null %0b, row_end %0b, frame_end %0b",
                 res_item.out_value, res_item.out_null, res_item.row_end, res_item.frame_end);
          fail_count++;
        end else begin
          want = grown_cells.pop_front();
          if (res_item.out_value !== want.out_value) begin
            $error("out_value: expected %0d, got %0d", want.out_value, res_item.out_value);
            fail_count++;
          end
          if (res_item.out_null !== want.out_null) begin
            $error("out_null: expected %0b, got %0b", want.out_null, res_item.out_null);
            fail_count++;
          end
          if (res_item.row_end !== want.row_end) begin
            $error("row_end: expected %0b, got %0b", want.row_end, res_item.row_end);
            fail_count++;
          end
          if (res_item.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, res_item.frame_end);
            fail_count++;
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned counted;
    int unsigned phase;
    int unsigned w, h, frames;
    logic [VAL_BITS-1:0] old_v, new_v;
    grow_cfg = '{image_width: WIDTH_RESET, image_height: HEIGHT_RESET, default: '0};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // 3x3 frame with diagonal growth: early flush, field extremes, stray cell, drain, late flush
    configure(3, 3, 1'b1, 1'b0, '0, 1'b0, '0);
    raster_items.push_back(flush_item());
    raster_items.push_back(cell_of(32'h0, 1'b1));
    raster_items.push_back(cell_of(32'h7FFF_FFFF, 1'b0));
    raster_items.push_back(cell_of(32'hFFFF_FFFF, 1'b1));
    raster_items.push_back(cell_of(32'h0, 1'b1));
    raster_items.push_back(cell_of(32'hFFFF_FFFF, 1'b1));
    raster_items.push_back(cell_of(32'h8000_0000, 1'b0));
    raster_items.push_back(cell_of(32'hFFFF_FFFF, 1'b0));
    raster_items.push_back(cell_of(32'h0, 1'b1));
    raster_items.push_back(cell_of(32'h0, 1'b0));
    raster_items.push_back(cell_of(32'h1234_5678, 1'b0));
    repeat (4) raster_items.push_back(flush_item());
    raster_items.push_back(flush_item());
    settle();

    // 2x2 frame with both overrides: diagonal-only growth into the far corner
    configure(2, 2, 1'b1, 1'b1, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF);
    raster_items.push_back(cell_of(32'd5, 1'b0));
    raster_items.push_back(cell_of(32'h0, 1'b1));
    raster_items.push_back(cell_of(32'h0, 1'b1));
    raster_items.push_back(cell_of(32'hFFFF_FFFF, 1'b1));
    repeat (3) raster_items.push_back(flush_item());
    settle();

    // Random settings, mostly small frames; a zero size, one long frame and a tall narrow one
    counted = 0;
    phase   = 0;
    while (counted < SMALL_ITEMS || phase < 6) begin
      case (phase)
        1:       begin w = 0;  h = 0;  end
        3:       begin w = 64; h = 8;  end
        5:       begin w = 1;  h = 40; end
        default: begin
          w = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
          h = $urandom_range(1, 10);
        end
      endcase
      old_v = (phase == 2) ? 32'h8000_0000 : (phase == 4) ? 32'h7FFF_FFFF : $urandom;
      new_v = (phase == 2) ? 32'h7FFF_FFFF : (phase == 4) ? 32'h8000_0000 : $urandom;
      configure(w, h, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), old_v,
                1'($urandom_range(0, 1)), new_v);
      w = clamp_dim(w, MAX_WIDTH);
      h = clamp_dim(h, MAX_HEIGHT);
      if (phase == 3) begin
        // queue the long frame at once so a receiver hold-off backs up the input
        counted += queue_frame(w, h, $urandom_range(5, 95));
      end else begin
        frames = $urandom_range(2, 5);
        repeat (frames) counted += queue_frame(w, h, $urandom_range(5, 95));
      end
      settle();
      phase++;
    end

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung run
  initial begin
    #(8 * 1_200_000);
    $display("Test completed with failures");
    $finish;
  end

endmodule
